// ----- src/hrsc_pkg.sv -----
// Shared types and codes for the hex record stream checker.
// No dependencies; used by every module of the block.
package hrsc_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] TYPE_LIMIT = 8'd6;
    localparam logic [7:0] TYPE_EOF   = 8'd1;

    typedef enum logic [2:0] {
        EV_DATA      = 3'd0,
        EV_RECORD_OK = 3'd1,
        EV_NO_COLON  = 3'd2,
        EV_BAD_TYPE  = 3'd3,
        EV_CHECKSUM  = 3'd4,
        EV_BAD_DIGIT = 3'd5
    } event_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       new_file;
    } hrsc_in_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [15:0] byte_address;
        logic [7:0]  record_type;
        logic [7:0]  byte_count;
        logic [15:0] record_number;
    } hrsc_out_t;

    typedef struct packed {
        logic      valid;
        hrsc_out_t item;
    } hrsc_result_t;

endpackage

// ----- src/hex_record_stream_checker.sv -----
// Top level of the hex record stream checker: input register, parser, result register.
// Depends on hrsc_pkg and hrsc_parser.
//
// Takes one character of a hex-record file per item and returns at most one result
// item per character: a data byte with its address, a record-ok status, or an error
// status after which the block drops characters until an item with new_file set; an
// end-of-file record-ok status stops it too. One character is taken every cycle unless
// a stalled result holds the input register. The input register holds the character
// and the result register, which drives m_valid, holds its result. A character with no
// result still passes through the input register. s_ready depends combinationally on
// m_ready through the single input register stage. terminator_count (reset 1) is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while idle (not enforced).
module hex_record_stream_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrsc_pkg::hrsc_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output hrsc_pkg::hrsc_out_t m_item,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data
);

    logic                   in_valid_reg;
    hrsc_pkg::hrsc_in_t     in_item_reg;
    logic                   out_valid_reg;
    hrsc_pkg::hrsc_out_t    out_item_reg;
    logic [1:0]             term_count_reg;
    logic                   advance;
    hrsc_pkg::hrsc_result_t result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_count_reg <= 2'd1;
        end else if (cfg_wr_en) begin
            term_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    hrsc_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (in_item_reg),
        .term_count (term_count_reg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            out_item_reg <= result.item;
        end
    end

endmodule

// ----- src/hrsc_parser.sv -----
// Record parser: parse state registers and the per-character next-state logic.
// Depends on hrsc_pkg.
module hrsc_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  hrsc_pkg::hrsc_in_t    item,
    input  logic [1:0]            term_count,
    output hrsc_pkg::hrsc_result_t result
);

    typedef enum logic [7:0] {
        PH_COLON   = 8'b0000_0001,
        PH_COUNT   = 8'b0000_0010,
        PH_ADDR_HI = 8'b0000_0100,
        PH_ADDR_LO = 8'b0000_1000,
        PH_TYPE    = 8'b0001_0000,
        PH_DATA    = 8'b0010_0000,
        PH_SUM     = 8'b0100_0000,
        PH_TERM    = 8'b1000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic        pending_reg, pending_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] address_reg, address_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  index_reg, index_next;
    logic [1:0]  term_left_reg, term_left_next;
    logic [15:0] records_reg, records_next;
    logic        stopped_reg, stopped_next;

    phase_t      ph_e;
    logic [3:0]  hi_e;
    logic        pend_e;
    logic [7:0]  count_e;
    logic [15:0] addr_e;
    logic [7:0]  type_e;
    logic [7:0]  sum_e;
    logic [7:0]  index_e;
    logic [1:0]  term_e;
    logic [15:0] records_e;
    logic        stop_e;

    logic        digit_ok;
    logic [3:0]  digit_val;
    logic [7:0]  byte_val;
    logic        emit;
    logic [2:0]  ev;
    logic [7:0]  ev_byte;
    logic [15:0] ev_addr;

    always_comb begin
        digit_ok  = 1'b1;
        digit_val = 4'd0;
        if (item.char_in >= 8'h30 && item.char_in <= 8'h39) begin
            digit_val = 4'(item.char_in - 8'h30);
        end else if (item.char_in >= 8'h41 && item.char_in <= 8'h46) begin
            digit_val = 4'(item.char_in - 8'h37);
        end else if (item.char_in >= 8'h61 && item.char_in <= 8'h66) begin
            digit_val = 4'(item.char_in - 8'h57);
        end else begin
            digit_ok = 1'b0;
        end
    end

    always_comb begin
        // clear file state ahead of the character
        ph_e      = item.new_file ? PH_COLON : phase_reg;
        hi_e      = item.new_file ? 4'd0  : high_nibble_reg;
        pend_e    = item.new_file ? 1'b0  : pending_reg;
        count_e   = item.new_file ? 8'd0  : count_reg;
        addr_e    = item.new_file ? 16'd0 : address_reg;
        type_e    = item.new_file ? 8'd0  : type_reg;
        sum_e     = item.new_file ? 8'd0  : sum_reg;
        index_e   = item.new_file ? 8'd0  : index_reg;
        term_e    = item.new_file ? 2'd0  : term_left_reg;
        records_e = item.new_file ? 16'd0 : records_reg;
        stop_e    = item.new_file ? 1'b0  : stopped_reg;

        phase_next       = ph_e;
        high_nibble_next = hi_e;
        pending_next     = pend_e;
        count_next       = count_e;
        address_next     = addr_e;
        type_next        = type_e;
        sum_next         = sum_e;
        index_next       = index_e;
        term_left_next   = term_e;
        records_next     = records_e;
        stopped_next     = stop_e;

        byte_val = {hi_e, digit_val};
        emit     = 1'b0;
        ev       = hrsc_pkg::EV_DATA;
        ev_byte  = 8'd0;
        ev_addr  = addr_e;

        if (!stop_e) begin
            unique case (ph_e)
                PH_TERM: begin
                    term_left_next = (term_e != 2'd0) ? term_e - 2'd1 : 2'd0;
                    if (term_left_next == 2'd0) begin
                        phase_next = PH_COLON;
                    end
                end
                PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA, PH_SUM: begin
                    if (!digit_ok) begin
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                        ev           = hrsc_pkg::EV_BAD_DIGIT;
                    end else if (!pend_e) begin
                        high_nibble_next = digit_val;
                        pending_next     = 1'b1;
                    end else begin
                        pending_next = 1'b0;
                        sum_next     = sum_e + byte_val;
                        unique case (ph_e)
                            PH_COUNT: begin
                                count_next = byte_val;
                                phase_next = PH_ADDR_HI;
                            end
                            PH_ADDR_HI: begin
                                address_next = {byte_val, 8'd0};
                                phase_next   = PH_ADDR_LO;
                            end
                            PH_ADDR_LO: begin
                                address_next = addr_e | {8'd0, byte_val};
                                phase_next   = PH_TYPE;
                            end
                            PH_TYPE: begin
                                type_next = byte_val;
                                if (byte_val >= hrsc_pkg::TYPE_LIMIT) begin
                                    stopped_next = 1'b1;
                                    emit         = 1'b1;
                                    ev           = hrsc_pkg::EV_BAD_TYPE;
                                end else begin
                                    index_next = 8'd0;
                                    phase_next = (count_e != 8'd0) ? PH_DATA : PH_SUM;
                                end
                            end
                            PH_DATA: begin
                                index_next = index_e + 8'd1;
                                if (index_next == count_e) begin
                                    phase_next = PH_SUM;
                                end
                                emit    = 1'b1;
                                ev      = hrsc_pkg::EV_DATA;
                                ev_byte = byte_val;
                                ev_addr = addr_e + {8'd0, index_e};
                            end
                            default: begin
                                emit = 1'b1;
                                if (sum_next != 8'd0) begin
                                    stopped_next = 1'b1;
                                    ev           = hrsc_pkg::EV_CHECKSUM;
                                end else begin
                                    ev = hrsc_pkg::EV_RECORD_OK;
                                    if (records_e != 16'hFFFF) begin
                                        records_next = records_e + 16'd1;
                                    end
                                    if (type_e == hrsc_pkg::TYPE_EOF) begin
                                        stopped_next = 1'b1;
                                        phase_next   = PH_COLON;
                                    end else begin
                                        term_left_next = term_count;
                                        phase_next = (term_count != 2'd0) ? PH_TERM : PH_COLON;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    high_nibble_next = 4'd0;
                    pending_next     = 1'b0;
                    count_next       = 8'd0;
                    address_next     = 16'd0;
                    type_next        = 8'd0;
                    sum_next         = 8'd0;
                    index_next       = 8'd0;
                    term_left_next   = 2'd0;
                    if (item.char_in == hrsc_pkg::COLON_CHAR) begin
                        phase_next = PH_COUNT;
                    end else begin
                        phase_next   = PH_COLON;
                        stopped_next = 1'b1;
                        emit         = 1'b1;
                        ev           = hrsc_pkg::EV_NO_COLON;
                        ev_addr      = 16'd0;
                    end
                end
            endcase
        end

        result.valid              = emit;
        result.item.event_res     = ev;
        result.item.data_byte     = ev_byte;
        result.item.byte_address  = ev_addr;
        result.item.record_type   = type_next;
        result.item.byte_count    = count_next;
        result.item.record_number = records_e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_COLON;
            high_nibble_reg <= 4'd0;
            pending_reg     <= 1'b0;
            count_reg       <= 8'd0;
            address_reg     <= 16'd0;
            type_reg        <= 8'd0;
            sum_reg         <= 8'd0;
            index_reg       <= 8'd0;
            term_left_reg   <= 2'd0;
            records_reg     <= 16'd0;
            stopped_reg     <= 1'b0;
        end else if (step) begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            pending_reg     <= pending_next;
            count_reg       <= count_next;
            address_reg     <= address_next;
            type_reg        <= type_next;
            sum_reg         <= sum_next;
            index_reg       <= index_next;
            term_left_reg   <= term_left_next;
            records_reg     <= records_next;
            stopped_reg     <= stopped_next;
        end
    end

endmodule

// ----- src/hrsc_checker.sv -----
// Port-level assertions for hex_record_stream_checker, bound to the top level.
// Depends on hrsc_pkg.
module hrsc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input hrsc_pkg::hrsc_out_t m_item
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.event_res <= hrsc_pkg::EV_BAD_DIGIT)
        else $error("event code out of range");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.event_res != hrsc_pkg::EV_DATA |-> m_item.data_byte == 8'd0)
        else $error("data byte set on a status item");

    a_no_colon_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.event_res == hrsc_pkg::EV_NO_COLON
        |-> m_item.byte_address == 16'd0 && m_item.record_type == 8'd0
            && m_item.byte_count == 8'd0)
        else $error("missing-colon status carries record fields");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind hex_record_stream_checker hrsc_checker u_hrsc_checker (.*);
